// File: rtl/oef_pkg.sv
// ----------------------------------------------------------------------------
// oef_pkg: shared types and constants for the one-euro filter channel
// Datapath widths, micro-op codes, register indexes and the command and
// status structs that connect the controller and the datapath.
// ----------------------------------------------------------------------------
package oef_pkg;

	// configuration register widths
	localparam int MODE_W     = 4;
	localparam int CUT_W      = 32;
	localparam int GAIN_W     = 24;
	localparam int FS_W       = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [FS_W-1:0] FS_RESET = 16'd10;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MODE  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MINC  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DCUT  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FS    = 3'd4;

	// filter modes
	localparam logic [MODE_W-1:0] MODE_PASS    = 4'd0;
	localparam logic [MODE_W-1:0] MODE_LOWPASS = 4'd1;
	localparam logic [MODE_W-1:0] MODE_EURO    = 4'd2;
	localparam logic [MODE_W-1:0] MODE_HYST    = 4'd3;

	// fixed-point scaling
	localparam int Q_BITS     = 16;              // w and fs scaling
	localparam int ALPHA_BITS = 16;              // alpha fraction bits
	localparam int ALPHA_W    = ALPHA_BITS + 1;  // alpha in [0, 1.0]
	localparam int RATE_W     = 32;              // smoothed and raw rate

	localparam logic [RATE_W-1:0] RATE_MAX = 32'h7FFF_FFFF;
	localparam logic [RATE_W-1:0] RATE_MIN = 32'h8000_0000;

	// 2*pi in Q.16
	localparam int TWO_PI_W = 19;
	localparam logic [TWO_PI_W-1:0] TWO_PI_Q16 = 19'd411775;

	// shared multiplier: signed 34 x signed 25
	localparam int MA_W   = 34;
	localparam int MB_W   = 25;
	localparam int PROD_W = MA_W + MB_W;
	localparam int ACC_W  = PROD_W + 1;
	localparam int Y_W    = ACC_W - ALPHA_BITS;

	// alpha division: w (35b), den (36b), numerator (52b)
	localparam int W_W    = CUT_W + TWO_PI_W - Q_BITS;
	localparam int DEN_W  = W_W + 1;
	localparam int NUM_W  = W_W + ALPHA_BITS + 1;
	localparam int REM_W  = DEN_W + 1;

	localparam int DIV_STEPS = ALPHA_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);
	localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

	// micro-ops
	localparam int OP_W = 4;
	localparam logic [OP_W-1:0] OP_NOP      = 4'd0;
	localparam logic [OP_W-1:0] OP_LOAD     = 4'd1;
	localparam logic [OP_W-1:0] OP_RATE_MUL = 4'd2;
	localparam logic [OP_W-1:0] OP_RATE_SAT = 4'd3;
	localparam logic [OP_W-1:0] OP_W_MUL    = 4'd4;
	localparam logic [OP_W-1:0] OP_W_DEN    = 4'd5;
	localparam logic [OP_W-1:0] OP_DIV_INIT = 4'd6;
	localparam logic [OP_W-1:0] OP_DIV_STEP = 4'd7;
	localparam logic [OP_W-1:0] OP_LP_MUL   = 4'd8;
	localparam logic [OP_W-1:0] OP_LP_FIN   = 4'd9;
	localparam logic [OP_W-1:0] OP_GAIN_MUL = 4'd10;
	localparam logic [OP_W-1:0] OP_GAIN_CUT = 4'd11;
	localparam logic [OP_W-1:0] OP_PASS     = 4'd12;
	localparam logic [OP_W-1:0] OP_HYST     = 4'd13;
	localparam logic [OP_W-1:0] OP_EMIT     = 4'd14;

	// cutoff source for the alpha computation
	localparam int CSEL_W = 2;
	localparam logic [CSEL_W-1:0] CUT_MIN   = 2'd0;
	localparam logic [CSEL_W-1:0] CUT_DERIV = 2'd1;
	localparam logic [CSEL_W-1:0] CUT_ADAPT = 2'd2;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [CSEL_W-1:0] cut_sel;
		logic              lp_sample;  // 1: lowpass the sample, 0: the rate
	} oef_cmd_t;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
	} oef_stat_t;

endpackage

// File: rtl/oef_ctrl.sv
// ----------------------------------------------------------------------------
// oef_ctrl: sequencer for the one-euro filter channel
// Walks each sample through its mode's micro-op sequence and owns the
// channel handshakes and the output valid flag.
// ----------------------------------------------------------------------------
module oef_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               cfg_ready,
	input  oef_pkg::oef_stat_t stat,
	output oef_pkg::oef_cmd_t  cmd
);

	localparam int ST_W = 4;
	localparam logic [ST_W-1:0] S_IDLE     = 4'd0;
	localparam logic [ST_W-1:0] S_RATE_MUL = 4'd1;
	localparam logic [ST_W-1:0] S_RATE_SAT = 4'd2;
	localparam logic [ST_W-1:0] S_W_MUL    = 4'd3;
	localparam logic [ST_W-1:0] S_W_DEN    = 4'd4;
	localparam logic [ST_W-1:0] S_DIV_INIT = 4'd5;
	localparam logic [ST_W-1:0] S_DIV_STEP = 4'd6;
	localparam logic [ST_W-1:0] S_LP_MUL   = 4'd7;
	localparam logic [ST_W-1:0] S_LP_FIN   = 4'd8;
	localparam logic [ST_W-1:0] S_GAIN_MUL = 4'd9;
	localparam logic [ST_W-1:0] S_GAIN_CUT = 4'd10;
	localparam logic [ST_W-1:0] S_PASS     = 4'd11;
	localparam logic [ST_W-1:0] S_HYST     = 4'd12;
	localparam logic [ST_W-1:0] S_EMIT     = 4'd13;

	logic [ST_W-1:0]                state_q, state_n;
	logic [oef_pkg::DIV_CNT_W-1:0]  cnt_q, cnt_n;
	logic [oef_pkg::CSEL_W-1:0]     csel_q, csel_n;
	logic                           lps_q, lps_n;
	logic                           out_valid_q;
	logic                           emit;
	logic [oef_pkg::OP_W-1:0]       op;

	always_comb begin
		state_n = state_q;
		cnt_n   = cnt_q;
		csel_n  = csel_q;
		lps_n   = lps_q;
		op      = oef_pkg::OP_NOP;
		emit    = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					op = oef_pkg::OP_LOAD;
					priority if (stat.mode == oef_pkg::MODE_LOWPASS) begin
						state_n = S_W_MUL;
						csel_n  = oef_pkg::CUT_MIN;
						lps_n   = 1'b1;
					end else if (stat.mode == oef_pkg::MODE_EURO) begin
						state_n = S_RATE_MUL;
						csel_n  = oef_pkg::CUT_DERIV;
						lps_n   = 1'b0;
					end else if (stat.mode == oef_pkg::MODE_HYST) begin
						state_n = S_HYST;
					end else begin
						state_n = S_PASS;
					end
				end
			end
			S_RATE_MUL: begin
				op      = oef_pkg::OP_RATE_MUL;
				state_n = S_RATE_SAT;
			end
			S_RATE_SAT: begin
				op      = oef_pkg::OP_RATE_SAT;
				state_n = S_W_MUL;
			end
			S_W_MUL: begin
				op      = oef_pkg::OP_W_MUL;
				state_n = S_W_DEN;
			end
			S_W_DEN: begin
				op      = oef_pkg::OP_W_DEN;
				state_n = S_DIV_INIT;
			end
			S_DIV_INIT: begin
				op      = oef_pkg::OP_DIV_INIT;
				cnt_n   = '0;
				state_n = S_DIV_STEP;
			end
			S_DIV_STEP: begin
				op = oef_pkg::OP_DIV_STEP;
				if (cnt_q == oef_pkg::DIV_LAST) begin
					state_n = S_LP_MUL;
				end else begin
					cnt_n = cnt_q + 1'b1;
				end
			end
			S_LP_MUL: begin
				op      = oef_pkg::OP_LP_MUL;
				state_n = S_LP_FIN;
			end
			S_LP_FIN: begin
				op = oef_pkg::OP_LP_FIN;
				if (lps_q) begin
					state_n = S_EMIT;
				end else begin
					state_n = S_GAIN_MUL;
					csel_n  = oef_pkg::CUT_ADAPT;
					lps_n   = 1'b1;
				end
			end
			S_GAIN_MUL: begin
				op      = oef_pkg::OP_GAIN_MUL;
				state_n = S_GAIN_CUT;
			end
			S_GAIN_CUT: begin
				op      = oef_pkg::OP_GAIN_CUT;
				state_n = S_W_MUL;
			end
			S_PASS: begin
				op      = oef_pkg::OP_PASS;
				state_n = S_EMIT;
			end
			S_HYST: begin
				op      = oef_pkg::OP_HYST;
				state_n = S_EMIT;
			end
			S_EMIT: begin
				// wait until the output register is free or being drained
				if (!out_valid_q || !out_stall) begin
					op      = oef_pkg::OP_EMIT;
					emit    = 1'b1;
					state_n = S_IDLE;
				end
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			csel_q      <= oef_pkg::CUT_MIN;
			lps_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			cnt_q   <= cnt_n;
			csel_q  <= csel_n;
			lps_q   <= lps_n;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_stall      = (state_q != S_IDLE);
	assign cfg_ready     = (state_q == S_IDLE);
	assign out_valid     = out_valid_q;
	assign cmd.op        = op;
	assign cmd.cut_sel   = csel_q;
	assign cmd.lp_sample = lps_q;

endmodule

// File: rtl/oef_dp.sv
// ----------------------------------------------------------------------------
// oef_dp: datapath for the one-euro filter channel
// Configuration and filter state, one shared multiplier, a one-bit-per-cycle
// restoring divider for alpha, saturation and the output register.
// ----------------------------------------------------------------------------
module oef_dp #(
	parameter int SAMPLE_WIDTH = 24,
	parameter int FRAC_BITS    = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  oef_pkg::oef_cmd_t                     cmd,
	output oef_pkg::oef_stat_t                    stat,
	input  logic signed [SAMPLE_WIDTH-1:0]        sample,
	input  logic                                  cfg_we,
	input  logic [oef_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [oef_pkg::CFG_DATA_W-1:0]        cfg_data,
	output logic signed [SAMPLE_WIDTH-1:0]        filtered
);

	localparam int SW    = SAMPLE_WIDTH;
	localparam int MAW   = oef_pkg::MA_W;
	localparam int MBW   = oef_pkg::MB_W;
	localparam int PW    = oef_pkg::PROD_W;
	localparam int AW    = oef_pkg::ACC_W;
	localparam int YW    = oef_pkg::Y_W;
	localparam int RW    = oef_pkg::RATE_W;
	localparam int CW    = oef_pkg::CUT_W;
	localparam int WW    = oef_pkg::W_W;
	localparam int DW    = oef_pkg::DEN_W;
	localparam int NW    = oef_pkg::NUM_W;
	localparam int RMW   = oef_pkg::REM_W;
	localparam int ALW   = oef_pkg::ALPHA_W;
	localparam int ALB   = oef_pkg::ALPHA_BITS;
	localparam int QB    = oef_pkg::Q_BITS;

	// hysteresis thresholds and the saturated 1.0
	localparam logic signed [63:0] HI_T_L = ((64'sd6 <<< FRAC_BITS) + 64'sd5) / 64'sd10;
	localparam logic signed [63:0] LO_T_L = ((64'sd4 <<< FRAC_BITS) + 64'sd5) / 64'sd10;
	localparam logic signed [63:0] SMAX_L = (64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1;
	localparam logic signed [63:0] ONE_L  = 64'sd1 <<< FRAC_BITS;
	localparam logic signed [63:0] ONE_SL = (ONE_L > SMAX_L) ? SMAX_L : ONE_L;

	localparam logic signed [MAW-1:0] HI_T    = HI_T_L[MAW-1:0];
	localparam logic signed [MAW-1:0] LO_T    = LO_T_L[MAW-1:0];
	localparam logic signed [SW-1:0]  ONE_SAT = ONE_SL[SW-1:0];
	localparam logic signed [SW-1:0]  SMAX    = {1'b0, {(SW-1){1'b1}}};
	localparam logic signed [SW-1:0]  SMIN    = {1'b1, {(SW-1){1'b0}}};
	localparam logic [AW-1:0]         RND     = AW'(1) << (ALB - 1);

	// configuration
	logic [oef_pkg::MODE_W-1:0] mode_q;
	logic [CW-1:0]              minc_q, dcut_q;
	logic [oef_pkg::GAIN_W-1:0] gain_q;
	logic [oef_pkg::FS_W-1:0]   fs_q;
	logic                       cfg_hit;

	// filter state
	logic signed [SW-1:0] last_q, held_q;
	logic signed [RW-1:0] smooth_q;

	// working registers
	logic signed [SW-1:0]  x_q, filtered_q;
	logic signed [RW-1:0]  rate_q;
	logic signed [PW-1:0]  p_q;
	logic [CW-1:0]         cut_q;
	logic [WW-1:0]         w_q;
	logic                  wz_q;
	logic [DW-1:0]         den_q, rem_q;
	logic [ALW-1:0]        nlo_q, q_q;

	// combinational
	logic signed [MAW-1:0] x_e, last_e, held_e, rate_e, smooth_e, prev_e;
	logic signed [MAW-1:0] mul_a;
	logic signed [MBW-1:0] mul_b;
	logic signed [PW-1:0]  mul_p;
	logic [ALW-1:0]        alpha;
	logic [RW-1:0]         mag;
	logic [CW-1:0]         fc;
	logic [RW-1:0]         rate_sat;
	logic [PW-RW:0]        p_hi;
	logic signed [AW-1:0]  acc;
	logic signed [YW-1:0]  y;
	logic [YW-SW:0]        y_hi_s;
	logic [YW-RW:0]        y_hi_r;
	logic signed [SW-1:0]  y_s;
	logic signed [RW-1:0]  y_r;
	logic [PW-1:0]         cut_sum;
	logic [CW-1:0]         cut_n;
	logic [WW-1:0]         w_n;
	logic [DW-1:0]         den_n;
	logic [NW-1:0]         num;
	logic [RMW-1:0]        t;
	logic [RMW-1:0]        t_sub;
	logic                  ge;
	logic                  pass_src;

	assign x_e      = {{(MAW-SW){x_q[SW-1]}}, x_q};
	assign last_e   = {{(MAW-SW){last_q[SW-1]}}, last_q};
	assign held_e   = {{(MAW-SW){held_q[SW-1]}}, held_q};
	assign rate_e   = {{(MAW-RW){rate_q[RW-1]}}, rate_q};
	assign smooth_e = {{(MAW-RW){smooth_q[RW-1]}}, smooth_q};
	assign prev_e   = cmd.lp_sample ? held_e : smooth_e;

	assign alpha = wz_q ? '0 : q_q;
	assign mag   = smooth_q[RW-1] ? (~smooth_q + 1'b1) : smooth_q;

	always_comb begin
		unique case (cmd.cut_sel)
			oef_pkg::CUT_MIN:   fc = minc_q;
			oef_pkg::CUT_DERIV: fc = dcut_q;
			default:            fc = cut_q;
		endcase
	end

	// shared multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (cmd.op)
			oef_pkg::OP_RATE_MUL: begin
				mul_a = x_e - last_e;
				mul_b = MBW'(fs_q);
			end
			oef_pkg::OP_W_MUL: begin
				mul_a = MAW'(fc);
				mul_b = MBW'(oef_pkg::TWO_PI_Q16);
			end
			oef_pkg::OP_LP_MUL: begin
				mul_a = cmd.lp_sample ? (x_e - held_e) : (rate_e - smooth_e);
				mul_b = MBW'(alpha);
			end
			oef_pkg::OP_GAIN_MUL: begin
				mul_a = MAW'(mag);
				mul_b = MBW'(gain_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// raw rate saturation
	assign p_hi     = p_q[PW-1:RW-1];
	assign rate_sat = ((&p_hi) | ~(|p_hi)) ? p_q[RW-1:0]
	                : (p_q[PW-1] ? oef_pkg::RATE_MIN : oef_pkg::RATE_MAX);

	// lowpass: prev*2^16 + (x - prev)*alpha, rounded half up
	assign acc    = AW'(p_q) + (AW'(prev_e) <<< ALB) + RND;
	assign y      = acc[AW-1:ALB];
	assign y_hi_s = y[YW-1:SW-1];
	assign y_hi_r = y[YW-1:RW-1];
	assign y_s    = ((&y_hi_s) | ~(|y_hi_s)) ? y[SW-1:0] : (y[YW-1] ? SMIN : SMAX);
	assign y_r    = ((&y_hi_r) | ~(|y_hi_r)) ? y[RW-1:0]
	              : (y[YW-1] ? oef_pkg::RATE_MIN : oef_pkg::RATE_MAX);

	// adaptive cutoff, saturated at all ones
	assign cut_sum = PW'(minc_q) + ($unsigned(p_q) >> FRAC_BITS);
	assign cut_n   = (|cut_sum[PW-1:CW]) ? '1 : cut_sum[CW-1:0];

	// alpha = round((w << 16) / (w + fs << 16))
	assign w_n   = p_q[WW+QB-1:QB];
	assign den_n = DW'(w_n) + (DW'(fs_q) << QB);
	assign num   = (NW'(w_q) << ALB) + NW'(den_q >> 1);
	assign t     = {rem_q, nlo_q[ALW-1]};
	assign ge    = (t >= {1'b0, den_q});
	assign t_sub = t - {1'b0, den_q};

	assign pass_src = (mode_q != oef_pkg::MODE_LOWPASS) && (mode_q != oef_pkg::MODE_EURO)
	               && (mode_q != oef_pkg::MODE_HYST);

	assign cfg_hit = cfg_we && (cfg_index <= oef_pkg::REG_FS);

	// configuration and filter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= oef_pkg::MODE_PASS;
			minc_q   <= '0;
			gain_q   <= '0;
			dcut_q   <= '0;
			fs_q     <= oef_pkg::FS_RESET;
			last_q   <= '0;
			held_q   <= '0;
			smooth_q <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					oef_pkg::REG_MODE: mode_q <= cfg_data[oef_pkg::MODE_W-1:0];
					oef_pkg::REG_MINC: minc_q <= cfg_data[CW-1:0];
					oef_pkg::REG_GAIN: gain_q <= cfg_data[oef_pkg::GAIN_W-1:0];
					oef_pkg::REG_DCUT: dcut_q <= cfg_data[CW-1:0];
					oef_pkg::REG_FS:   fs_q   <= cfg_data[oef_pkg::FS_W-1:0];
					default: begin
					end
				endcase
			end
			if (cfg_hit) begin
				last_q   <= '0;
				held_q   <= '0;
				smooth_q <= '0;
			end else begin
				unique case (cmd.op)
					oef_pkg::OP_RATE_SAT, oef_pkg::OP_PASS: begin
						last_q <= x_q;
					end
					oef_pkg::OP_LP_FIN: begin
						if (cmd.lp_sample) begin
							held_q <= y_s;
						end else begin
							smooth_q <= y_r;
						end
					end
					oef_pkg::OP_HYST: begin
						if (x_e > HI_T) begin
							held_q <= ONE_SAT;
						end else if (x_e < LO_T) begin
							held_q <= '0;
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		unique case (cmd.op)
			oef_pkg::OP_LOAD: begin
				x_q <= sample;
			end
			oef_pkg::OP_RATE_MUL, oef_pkg::OP_W_MUL,
			oef_pkg::OP_LP_MUL, oef_pkg::OP_GAIN_MUL: begin
				p_q <= mul_p;
			end
			oef_pkg::OP_RATE_SAT: begin
				rate_q <= rate_sat;
			end
			oef_pkg::OP_W_DEN: begin
				w_q   <= w_n;
				wz_q  <= (w_n == '0);
				den_q <= den_n;
			end
			oef_pkg::OP_DIV_INIT: begin
				rem_q <= DW'(num[NW-1:ALW]);
				nlo_q <= num[ALW-1:0];
				q_q   <= '0;
			end
			oef_pkg::OP_DIV_STEP: begin
				rem_q <= ge ? t_sub[DW-1:0] : t[DW-1:0];
				nlo_q <= nlo_q << 1;
				q_q   <= {q_q[ALW-2:0], ge};
			end
			oef_pkg::OP_GAIN_CUT: begin
				cut_q <= cut_n;
			end
			oef_pkg::OP_EMIT: begin
				filtered_q <= pass_src ? x_q : held_q;
			end
			default: begin
			end
		endcase
	end

	assign stat.mode = mode_q;
	assign filtered  = filtered_q;

endmodule

// File: rtl/one_euro_filter_channel.sv
// ----------------------------------------------------------------------------
// one_euro_filter_channel: one sensor channel filter
// Pass, one-pole lowpass, one-euro and hysteresis modes on signed fixed-point
// samples, built as a sequencer over a shared multiplier and serial divider.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / sample): one transaction per sample.
//   in_stall is high while a sample is being worked on.
//   Output channel (out_valid / out_stall / filtered): one transaction per
//   sample, in order. The result sits in an output register, so the next
//   sample is taken while a finished one is still waiting.
//   Config channel (cfg_valid / cfg_ready / cfg_index / cfg_data): a write
//   to registers 0..4 sets that register and clears the filter state; other
//   indexes are dropped. cfg_ready is high only while no sample is in work.
//   The lowpass modes use the 17-step restoring divider that forms alpha,
//   run once (lowpass) or twice (one-euro).
//   Result shows on out_valid in the cycle after the last sequencer step.
//   If the receiver stalls, the finished result holds and the sequencer
//   waits in its last step until the output register frees up.
//   Reset (arst_n low) sets mode pass, cutoffs and gain 0, sample rate 10 Hz,
//   and clears the filter state; no clearing pass is needed.
// ----------------------------------------------------------------------------
module one_euro_filter_channel #(
	parameter int SAMPLE_WIDTH = 24,
	parameter int FRAC_BITS    = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic signed [SAMPLE_WIDTH-1:0]        sample,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic signed [SAMPLE_WIDTH-1:0]        filtered,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [oef_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [oef_pkg::CFG_DATA_W-1:0]        cfg_data
);

	oef_pkg::oef_cmd_t  cmd;
	oef_pkg::oef_stat_t stat;
	logic               cfg_we;

	// config writes land only while the sequencer is idle
	assign cfg_we = cfg_valid && cfg_ready;

	oef_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cfg_ready (cfg_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	oef_dp #(
		.SAMPLE_WIDTH (SAMPLE_WIDTH),
		.FRAC_BITS    (FRAC_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.sample    (sample),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.filtered  (filtered)
	);

	// an accepted sample always puts the block to work
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("sample transaction accepted but sequencer stayed idle");

	// a new result only comes out of a busy sequencer
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result transaction appeared without work in progress");

	// the sequencer goes idle only by handing a result to the output register
	a_idle_after_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(in_stall) |-> out_valid)
		else $error("sequencer went idle without a pending result");

endmodule

// File: tb/one_euro_filter_channel_test.sv
// ----------------------------------------------------------------------------
// one_euro_filter_channel_test: self-checking bench for the filter channel
// Drives samples and register writes through the valid/stall and valid/ready
// ports, predicts every filtered value with a bit-exact fixed-point model of
// the pass, lowpass, one-euro and hysteresis modes, and checks each result
// in order. Directed corner cases come first, then randomized phases with
// random idling on both sides, a long receiver hold-off and full drains.
// ----------------------------------------------------------------------------
module one_euro_filter_channel_test;
	timeunit 1ns;
	timeprecision 1ps;

	import oef_pkg::*;

	localparam int SW   = 24;   // sample width
	localparam int FRAC = 16;   // sample fraction bits

	localparam int          HALF_PERIOD  = 5;
	localparam int          RESET_CYCLES = 4;
	localparam int          MAX_IDLE     = 17;    // per-transaction idle draw
	localparam int          LONG_HOLD    = 400;   // receiver hold-off, cycles
	localparam int          SETTLE       = 4;     // quiet cycles before a write
	localparam int          TAIL         = 64;    // cycles after the last result
	localparam int          RAND_ITEMS   = 1350;
	localparam int          MAX_SHOWN    = 10;
	// The 8 ms limit is about six times the slowest run (one-euro step plus
	// both worst idle draws per sample).
	localparam int unsigned LIMIT_NS     = 8_000_000;

	// fixed-point constants of the filter
	localparam longint TWO_PI_FX = 411775;               // 2*pi, Q.16
	localparam longint UNITY     = longint'(1) << 16;    // alpha of 1.0
	localparam longint HALF_LSB  = longint'(1) << 15;
	localparam longint S_LO      = -(longint'(1) << (SW - 1));
	localparam longint S_HI      = (longint'(1) << (SW - 1)) - 1;
	localparam longint I32_LO    = -(longint'(1) << 31);
	localparam longint I32_HI    = (longint'(1) << 31) - 1;
	localparam longint CUT_TOP   = (longint'(1) << 32) - 1;
	localparam longint HYST_HI   = ((longint'(6) << FRAC) + 5) / 10;   // 0.6
	localparam longint HYST_LO   = ((longint'(4) << FRAC) + 5) / 10;   // 0.4
	localparam longint ONE_FX    = longint'(1) << FRAC;                // 1.0

	localparam logic signed [SW-1:0] S_MAX = {1'b0, {(SW-1){1'b1}}};
	localparam logic signed [SW-1:0] S_MIN = {1'b1, {(SW-1){1'b0}}};

	// register indexes past the map: the block drops these writes
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = REG_FS + 1'b1;
	localparam logic [CFG_IDX_W-1:0] REG_TOP   = '1;
	// highest mode code; unassigned codes behave as pass
	localparam logic [MODE_W-1:0]    MODE_TOP  = '1;

	typedef enum bit {ROW_SAMPLE, ROW_WRITE} row_kind_e;
	typedef enum logic [1:0] {STY_WIDE, STY_WALK, STY_BAND} sample_style_e;

	// one line of the directed plan: a register write or a sample, with an
	// optional hand-written expected value
	typedef struct packed {
		row_kind_e              kind;
		logic [CFG_IDX_W-1:0]   idx;
		logic [CFG_DATA_W-1:0]  data;
		logic signed [SW-1:0]   smp;
		bit                     typed;
		logic signed [SW-1:0]   want;
	} plan_row_t;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   in_valid;
	logic                   in_stall;
	logic signed [SW-1:0]   sample;
	logic                   out_valid;
	logic                   out_stall;
	logic signed [SW-1:0]   filtered;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	// predictor copy of the registers and the filter state
	logic [MODE_W-1:0]      cur_mode;
	logic [CUT_W-1:0]       cur_min_cut;
	logic [GAIN_W-1:0]      cur_gain;
	logic [CUT_W-1:0]       cur_dcut;
	logic [FS_W-1:0]        cur_fs;
	longint                 prev_sample;
	longint                 prev_output;
	longint                 rate_avg;

	logic signed [SW-1:0]   filtered_due[$];   // expected filtered values, in order
	int unsigned            bad_results;
	bit                     calm;              // no idling on either side
	int unsigned            hold_req;          // pending long receiver hold-off

	one_euro_filter_channel #(
		.SAMPLE_WIDTH(SW),
		.FRAC_BITS(FRAC)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.sample(sample),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.filtered(filtered),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #(HALF_PERIOD) clk = ~clk;

	// ------------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------------

	function automatic longint clip(input longint v, input longint lo, input longint hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	// alpha = w / (w + fs) in Q.16, rounded half up; w = 2*pi*fc truncated
	function automatic longint alpha_for(input longint fc);
		longint w;
		longint den;
		w = (fc * TWO_PI_FX) >> 16;
		if (w == 0)
			return 0;
		den = w + (longint'(cur_fs) << 16);
		return ((w << 16) + den / 2) / den;
	endfunction

	// x*alpha + prev*(1 - alpha), rounded half toward +inf
	function automatic longint blend(input longint x, input longint prev, input longint a);
		longint acc;
		acc = x * a + prev * (UNITY - a);
		return (acc + HALF_LSB) >>> 16;
	endfunction

	function automatic logic signed [SW-1:0] predict_filtered(input logic signed [SW-1:0] smp);
		longint x;
		longint rate;
		longint mag;
		longint cut;
		x = longint'(smp);
		case (cur_mode)
			MODE_LOWPASS: begin
				prev_output = clip(blend(x, prev_output, alpha_for(longint'(cur_min_cut))),
					S_LO, S_HI);
				return SW'(prev_output);
			end
			MODE_EURO: begin
				// rate in units per second, smoothed at the derivative cutoff
				rate = clip((x - prev_sample) * longint'(cur_fs), I32_LO, I32_HI);
				rate_avg = clip(blend(rate, rate_avg, alpha_for(longint'(cur_dcut))),
					I32_LO, I32_HI);
				prev_sample = x;
				mag = (rate_avg < 0) ? -rate_avg : rate_avg;
				// adaptive cutoff, saturating at the top of the unsigned range
				cut = longint'(cur_min_cut) + ((longint'(cur_gain) * mag) >> FRAC);
				if (cut > CUT_TOP)
					cut = CUT_TOP;
				prev_output = clip(blend(x, prev_output, alpha_for(cut)), S_LO, S_HI);
				return SW'(prev_output);
			end
			MODE_HYST: begin
				// a sample exactly on a threshold holds the output
				if (x > HYST_HI)
					prev_output = clip(ONE_FX, S_LO, S_HI);
				else if (x < HYST_LO)
					prev_output = 0;
				return SW'(prev_output);
			end
			default: begin
				prev_sample = x;
				return smp;
			end
		endcase
	endfunction

	// ------------------------------------------------------------------------
	// Driving tasks
	// ------------------------------------------------------------------------

	// Register write. The block only takes writes while idle, so the input
	// side is parked and every outstanding result is collected first.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		in_valid <= 1'b0;
		while (filtered_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		cfg_valid <= 1'b0;
		case (idx)
			REG_MODE: cur_mode    = data[MODE_W-1:0];
			REG_MINC: cur_min_cut = data[CUT_W-1:0];
			REG_GAIN: cur_gain    = data[GAIN_W-1:0];
			REG_DCUT: cur_dcut    = data[CUT_W-1:0];
			REG_FS:   cur_fs      = data[FS_W-1:0];
			default: ;
		endcase
		// any mapped write clears the filter state; dropped writes keep it
		if (idx <= REG_FS) begin
			prev_sample = 0;
			prev_output = 0;
			rate_avg    = 0;
		end
	endtask

	// One sample transaction. Valid stays up after acceptance so a zero gap
	// gives back-to-back transactions.
	task automatic send_sample(input logic signed [SW-1:0] smp, input bit typed,
			input logic signed [SW-1:0] want);
		int unsigned          gap;
		logic signed [SW-1:0] due;
		gap = calm ? 0 : $urandom_range(0, MAX_IDLE);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		sample   <= smp;
		do @(posedge clk); while (in_stall !== 1'b0);
		due = predict_filtered(smp);
		filtered_due.push_back(typed ? want : due);
	endtask

	function automatic plan_row_t write_row(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		plan_row_t r;
		r      = '0;
		r.kind = ROW_WRITE;
		r.idx  = idx;
		r.data = data;
		return r;
	endfunction

	function automatic plan_row_t sample_row(input logic signed [SW-1:0] smp, input bit typed,
			input logic signed [SW-1:0] want);
		plan_row_t r;
		r       = '0;
		r.kind  = ROW_SAMPLE;
		r.smp   = smp;
		r.typed = typed;
		r.want  = want;
		return r;
	endfunction

	// cutoff in Q16.16 Hz: extremes, any value, or a realistic 0..40 Hz
	function automatic logic [CFG_DATA_W-1:0] pick_cutoff();
		case ($urandom_range(0, 6))
			0:       return '0;
			1:       return '1;
			2:       return $urandom();
			default: return $urandom_range(0, 40 << 16);
		endcase
	endfunction

	task automatic flag_error(input string msg);
		bad_results++;
		if (bad_results <= MAX_SHOWN)
			$display("%s", msg);
	endtask

	// ------------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------------
	initial begin
		plan_row_t            plan[$];
		plan_row_t            row;
		int                   rand_sent;
		int                   phase;
		int                   n;
		int unsigned          step;
		logic [MODE_W-1:0]    mode;
		logic [CFG_DATA_W-1:0] data;
		logic signed [SW-1:0] walk;
		logic signed [SW-1:0] smp;
		sample_style_e        style;

		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		sample    <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data  <= '0;

		cur_mode    = MODE_PASS;
		cur_min_cut = '0;
		cur_gain    = '0;
		cur_dcut    = '0;
		cur_fs      = FS_RESET;
		prev_sample = 0;
		prev_output = 0;
		rate_avg    = 0;
		calm        = 1'b0;
		hold_req    = 0;
		bad_results = 0;
		walk        = '0;

		// Directed plan. Pass mode straight out of reset.
		plan.push_back(sample_row('0, 1, '0));
		plan.push_back(sample_row(S_MAX, 1, S_MAX));
		plan.push_back(sample_row(S_MIN, 1, S_MIN));
		// hysteresis; upper data bits set to check the mode field is masked
		plan.push_back(write_row(REG_MODE, {28'hFFF_FFFF, MODE_HYST}));
		plan.push_back(sample_row(SW'(HYST_HI), 1, '0));             // on 0.6: hold
		plan.push_back(sample_row(SW'(HYST_HI + 1), 1, SW'(ONE_FX)));
		plan.push_back(sample_row(SW'(HYST_LO), 1, SW'(ONE_FX)));     // on 0.4: hold
		plan.push_back(sample_row(SW'(HYST_LO - 1), 1, '0));
		plan.push_back(sample_row(S_MAX, 1, SW'(ONE_FX)));
		plan.push_back(sample_row(S_MIN, 1, '0));
		// lowpass with zero cutoff: alpha 0, output holds its cleared value
		plan.push_back(write_row(REG_MODE, CFG_DATA_W'(MODE_LOWPASS)));
		plan.push_back(sample_row(S_MAX, 1, '0));
		// max cutoff and zero sample rate: alpha 1, output follows the input
		plan.push_back(write_row(REG_MINC, '1));
		plan.push_back(write_row(REG_FS, 32'hFFFF_0000));
		plan.push_back(sample_row(S_MIN, 1, S_MIN));
		plan.push_back(sample_row(SW'(12345), 1, SW'(12345)));
		// one-euro at the extremes, first with zero sample rate
		plan.push_back(write_row(REG_MODE, CFG_DATA_W'(MODE_EURO)));
		plan.push_back(sample_row(S_MAX, 0, '0));
		plan.push_back(sample_row(S_MIN, 0, '0));
		plan.push_back(write_row(REG_GAIN, '1));
		plan.push_back(write_row(REG_DCUT, '1));
		plan.push_back(write_row(REG_FS, 32'h0000_FFFF));
		plan.push_back(sample_row(S_MIN, 0, '0));
		plan.push_back(sample_row(S_MAX, 0, '0));
		// unmapped index mid-stream: dropped, state must survive
		plan.push_back(write_row(REG_SPARE, 32'hA5C3_0F96));
		plan.push_back(sample_row(S_MIN, 0, '0));
		plan.push_back(sample_row('0, 0, '0));
		// unassigned mode code falls back to pass
		plan.push_back(write_row(REG_MODE, CFG_DATA_W'(MODE_TOP)));
		plan.push_back(sample_row('1, 1, '1));
		plan.push_back(write_row(REG_TOP, '1));
		plan.push_back(sample_row(SW'(1), 1, SW'(1)));

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			row = plan[i];
			if (row.kind == ROW_WRITE)
				write_reg(row.idx, row.data);
			else
				send_sample(row.smp, row.typed, row.want);
		end

		// Random phases: each starts from a drained block with a fresh mode and
		// randomly rewritten registers, then streams samples of one flavor.
		rand_sent = 0;
		phase     = 0;
		while (rand_sent < RAND_ITEMS) begin
			phase++;
			case ($urandom_range(0, 9))
				0:       mode = MODE_PASS;
				1, 2:    mode = MODE_LOWPASS;
				7, 8:    mode = MODE_HYST;
				9:       mode = MODE_W'($urandom_range(MODE_HYST + 1, MODE_TOP));
				default: mode = MODE_EURO;
			endcase
			data = $urandom();
			data[MODE_W-1:0] = mode;
			write_reg(REG_MODE, data);
			if ($urandom_range(0, 1))
				write_reg(REG_MINC, pick_cutoff());
			if ($urandom_range(0, 1))
				write_reg(REG_DCUT, pick_cutoff());
			if ($urandom_range(0, 1)) begin
				data = $urandom();
				case ($urandom_range(0, 4))
					0:       data[GAIN_W-1:0] = '0;
					1:       data[GAIN_W-1:0] = '1;
					2:       ;
					default: data[GAIN_W-1:0] = GAIN_W'($urandom_range(0, 1 << 16));
				endcase
				write_reg(REG_GAIN, data);
			end
			if ($urandom_range(0, 1)) begin
				data = $urandom();
				case ($urandom_range(0, 5))
					0:       data[FS_W-1:0] = FS_W'(1);
					1:       data[FS_W-1:0] = '1;
					2:       data[FS_W-1:0] = '0;
					3:       ;
					default: data[FS_W-1:0] = FS_W'($urandom_range(10, 1000));
				endcase
				write_reg(REG_FS, data);
			end
			if ($urandom_range(0, 7) == 0)
				write_reg(CFG_IDX_W'($urandom_range(REG_SPARE, REG_TOP)), $urandom());

			calm = ($urandom_range(0, 4) == 0);
			// twice in the run the receiver sits out a long stretch while the
			// sender keeps pushing, so the block backs up and stalls its input
			if (phase == 3 || phase == 12) begin
				calm     = 1'b1;
				hold_req = LONG_HOLD;
			end

			if (mode == MODE_HYST)
				style = ($urandom_range(0, 3) != 0) ? STY_BAND : STY_WIDE;
			else
				style = ($urandom_range(0, 2) != 0) ? STY_WALK : STY_WIDE;
			step = ($urandom_range(0, 5) == 0) ? (1 << 20) : $urandom_range(1, 4000);
			n    = $urandom_range(20, 70);

			repeat (n) begin
				case (style)
					STY_WALK: begin
						walk = walk + SW'(int'($urandom_range(0, 2 * step)) - int'(step));
						smp  = walk;
					end
					STY_BAND: begin
						if ($urandom_range(0, 5) == 0)
							smp = SW'($urandom());
						else
							smp = SW'($urandom_range(HYST_LO - 4, HYST_HI + 4));
					end
					default: smp = SW'($urandom());
				endcase
				send_sample(smp, 0, '0);
				rand_sent++;
			end
		end

		// collect everything, then give the block time to show any stray result
		in_valid <= 1'b0;
		while (filtered_due.size() != 0)
			@(posedge clk);
		repeat (TAIL) @(posedge clk);

		if (bad_results == 0 && filtered_due.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Result side: random stall per transaction, in-order check
	// ------------------------------------------------------------------------
	initial begin
		int unsigned          wait_n;
		logic signed [SW-1:0] due;

		out_stall <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (hold_req != 0) begin
				wait_n   = hold_req;
				hold_req = 0;
			end else begin
				wait_n = calm ? 0 : $urandom_range(0, MAX_IDLE);
			end
			if (wait_n != 0) begin
				out_stall <= 1'b1;
				repeat (wait_n) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (out_valid !== 1'b1);
			if (filtered_due.size() == 0) begin
				flag_error($sformatf("%0t: unexpected result, filtered=%0d", $time, filtered));
			end else begin
				due = filtered_due.pop_front();
				if (filtered !== due)
					flag_error($sformatf("%0t: filtered mismatch, expected %0d got %0d",
						$time, due, filtered));
			end
		end
	end

	// hang guard
	initial begin
		#(LIMIT_NS);
		$display("Verification failed");
		$finish;
	end

endmodule

// File: sim.f
rtl/oef_pkg.sv
rtl/oef_ctrl.sv
rtl/oef_dp.sv
rtl/one_euro_filter_channel.sv
tb/one_euro_filter_channel_test.sv
